// File: rtl/temp_sensor_slew_filter_average_macros.svh
// assertion macros for the temperature sensor filter rtl
`ifndef TEMP_SENSOR_SLEW_FILTER_AVERAGE_MACROS_SVH
`define TEMP_SENSOR_SLEW_FILTER_AVERAGE_MACROS_SVH

// same-cycle implication, checked out of reset
`define TSA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define TSA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/tsa_pkg.sv
// shared types and constants for the temperature sensor filter
`timescale 1ns / 1ps

package tsa_pkg;

   localparam int HISTORY_DEPTH = 60;

   localparam int SAMPLE_W = 12;
   localparam int TEMP_W   = 14;
   localparam int OFFSET_W = 10;
   localparam int SUM_W    = 20;
   localparam int CNT_W    = 6;
   localparam int RAW_W    = 13;
   localparam int PROD_W   = 25;
   localparam int REM_W    = 6;
   localparam int STEP_W   = 5;

   localparam int ADC_ZERO    = 1855;
   localparam int SCALE_NUM   = 6670;
   localparam int SCALE_SHIFT = 12;

   // request kind codes
   localparam logic [1:0] KIND_MEASURE = 2'd0;
   localparam logic [1:0] KIND_RESTART = 2'd1;
   localparam logic [1:0] KIND_AVERAGE = 2'd2;

   typedef enum logic [1:0] {
      OP_MEASURE,
      OP_RESTART,
      OP_AVERAGE,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [SAMPLE_W-1:0]   sample;
      logic                  filter;
   } item_type;

   typedef struct packed {
      logic                start;
      logic [SUM_W-1:0]    dividend;
      logic [CNT_W-1:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [SUM_W-1:0]    quotient;
   } div_rsp_type;

endpackage

// File: rtl/temp_sensor_slew_filter_average.sv
// top level of the temperature sensor slew filter and history average
`timescale 1ns / 1ps

// Converts 12-bit sensor samples to tenths of a degree Celsius, applies the
// calibration offset and an optional one-step slew filter, and logs each kept
// temperature into a running sum and count of up to HISTORY_DEPTH values. An
// average request returns the truncated mean of the log and empties it; a
// restart request empties the log and takes one unfiltered sample. Every
// request gives exactly one response. A two-entry request queue sits in front
// of the execution unit, so while a response waits at the output up to three
// requests are taken: one held in the execution unit and two in the queue. A
// measure or restart request steps through the execution unit as dequeue,
// multiply, filter and log, then response; an average request waits on the
// restoring divider, which retires one quotient bit per cycle over the
// 20-bit sum with a start and a finish handoff, and skips it if the log is
// empty. The offset register is written through the csr port at any time
// the block is idle; its write is always taken.

module temp_sensor_slew_filter_average
   import tsa_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // offset register write
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic signed [OFFSET_W-1:0] csr_temp_offset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_kind,
   input  logic [SAMPLE_W-1:0]        req_adc_sample,
   input  logic                       req_filter_on,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [TEMP_W-1:0]   rsp_current_temp,
   output logic signed [TEMP_W-1:0]   rsp_average_temp,
   output logic [CNT_W-1:0]           rsp_history_count,
   output logic                       rsp_history_full
);

   logic signed [OFFSET_W-1:0] temp_offset_ff;
   logic                       q_valid;
   item_type                   q_item;
   logic                       q_pop;
   div_req_type                div_req;
   div_rsp_type                div_rsp;

   // calibration offset, resets to zero
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_offset_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         temp_offset_ff <= csr_temp_offset;
      end
   end

   // request decode and queue
   tsa_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_adc_sample (req_adc_sample),
      .req_filter_on  (req_filter_on),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   // divider for the history average
   tsa_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // execution and response register
   tsa_back u_back (
      .clock             (clock),
      .reset             (reset),
      .temp_offset       (temp_offset_ff),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .div_req           (div_req),
      .div_rsp           (div_rsp),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_current_temp  (rsp_current_temp),
      .rsp_average_temp  (rsp_average_temp),
      .rsp_history_count (rsp_history_count),
      .rsp_history_full  (rsp_history_full)
   );

endmodule

// File: rtl/tsa_front.sv
// request intake: decodes the kind and holds up to two requests
`timescale 1ns / 1ps

module tsa_front
   import tsa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_kind,
   input  logic [SAMPLE_W-1:0] req_adc_sample,
   input  logic                req_filter_on,
   output logic                q_valid,
   output item_type            q_item,
   input  logic                q_pop
);

   item_type   mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   item_type   item_in;
   logic       push;

   always_comb begin
      item_in.sample = req_adc_sample;
      item_in.filter = 1'b0;
      case (req_kind)
         KIND_MEASURE: begin
            item_in.op     = OP_MEASURE;
            item_in.filter = req_filter_on;
         end
         KIND_RESTART: item_in.op = OP_RESTART;
         KIND_AVERAGE: item_in.op = OP_AVERAGE;
         default:      item_in.op = OP_NONE;
      endcase
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (q_pop && q_valid) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         case ({push, q_pop && q_valid})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// File: rtl/tsa_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module tsa_div
   import tsa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [SUM_W-1:0]  quot_ff;
   logic [CNT_W-1:0]  divisor_ff;
   logic [REM_W:0]    trial;
   logic [REM_W:0]    diff;
   logic              fits;
   logic [REM_W-1:0]  rem_in;

   always_comb begin
      trial  = {rem_ff, quot_ff[SUM_W-1]};
      diff   = trial - {1'b0, divisor_ff};
      fits   = (trial >= {1'b0, divisor_ff});
      rem_in = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff    <= 1'b1;
            step_ff    <= '0;
            rem_ff     <= '0;
            quot_ff    <= div_req.dividend;
            divisor_ff <= div_req.divisor;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            quot_ff <= {quot_ff[SUM_W-2:0], fits};
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

// File: rtl/tsa_back.sv
// request execution: conversion, slew filter, history and result register
`timescale 1ns / 1ps
`include "temp_sensor_slew_filter_average_macros.svh"

module tsa_back
   import tsa_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [OFFSET_W-1:0] temp_offset,
   input  logic                     q_valid,
   input  item_type                 q_item,
   output logic                     q_pop,
   output div_req_type              div_req,
   input  div_rsp_type              div_rsp,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [TEMP_W-1:0] rsp_current_temp,
   output logic signed [TEMP_W-1:0] rsp_average_temp,
   output logic [CNT_W-1:0]         rsp_history_count,
   output logic                     rsp_history_full
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_APPLY,
      S_DIV,
      S_DONE
   } state_type;

   localparam logic signed [PROD_W-1:0] SCALE_C  = PROD_W'(SCALE_NUM);
   localparam logic signed [PROD_W-1:0] ROUND_C  = PROD_W'((1 << SCALE_SHIFT) - 1);
   localparam logic signed [RAW_W-1:0]  ZERO_C   = RAW_W'(ADC_ZERO);

   state_type                 state_ff;
   item_type                  item_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [TEMP_W-1:0]  filtered_ff;
   logic signed [SUM_W-1:0]   log_sum_ff;
   logic [CNT_W-1:0]          log_count_ff;
   logic signed [TEMP_W-1:0]  avg_ff;
   logic                      div_start_ff;
   logic                      rsp_valid_ff;
   logic signed [TEMP_W-1:0]  rsp_current_ff;
   logic signed [TEMP_W-1:0]  rsp_average_ff;
   logic [CNT_W-1:0]          rsp_count_ff;
   logic                      rsp_full_ff;

   logic signed [RAW_W-1:0]   raw;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [PROD_W-1:0]  prod_adj;
   logic signed [PROD_W-1:0]  quot_conv;
   logic signed [TEMP_W-1:0]  meas;
   logic signed [TEMP_W-1:0]  filt_in;
   logic                      log_room;
   logic [SUM_W-1:0]          sum_mag;
   logic [SUM_W-1:0]          quot_signed;
   logic signed [TEMP_W-1:0]  avg_in;
   logic                      rsp_load;

   always_comb begin
      // sample minus zero point, then the scale multiply
      raw      = $signed({1'b0, item_ff.sample}) - ZERO_C;
      prod_in  = PROD_W'(raw) * SCALE_C;
      // divide by 4096 truncating toward zero
      prod_adj  = prod_ff + (prod_ff[PROD_W-1] ? ROUND_C : '0);
      quot_conv = prod_adj >>> SCALE_SHIFT;
      meas      = quot_conv[TEMP_W-1:0] + TEMP_W'(temp_offset);
      if (item_ff.filter) begin
         if (meas > filtered_ff) begin
            filt_in = filtered_ff + 14'sd1;
         end else if (meas < filtered_ff) begin
            filt_in = filtered_ff - 14'sd1;
         end else begin
            filt_in = filtered_ff;
         end
      end else begin
         filt_in = meas;
      end
      log_room    = (log_count_ff < CNT_W'(HISTORY_DEPTH));
      sum_mag     = log_sum_ff[SUM_W-1] ? SUM_W'(-log_sum_ff) : log_sum_ff;
      quot_signed = log_sum_ff[SUM_W-1] ? -div_rsp.quotient : div_rsp.quotient;
      avg_in      = quot_signed[TEMP_W-1:0];
   end

   assign q_pop            = (state_ff == S_IDLE) && q_valid;
   assign rsp_load         = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   assign div_req.start    = div_start_ff;
   assign div_req.dividend = sum_mag;
   assign div_req.divisor  = log_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         filtered_ff  <= '0;
         log_sum_ff   <= '0;
         log_count_ff <= '0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  item_ff  <= q_item;
                  avg_ff   <= '0;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               prod_ff <= prod_in;
               case (item_ff.op)
                  OP_MEASURE: state_ff <= S_APPLY;
                  OP_RESTART: begin
                     log_sum_ff   <= '0;
                     log_count_ff <= '0;
                     state_ff     <= S_APPLY;
                  end
                  OP_AVERAGE: begin
                     if (log_count_ff != '0) begin
                        div_start_ff <= 1'b1;
                        state_ff     <= S_DIV;
                     end else begin
                        state_ff <= S_DONE;
                     end
                  end
                  default: state_ff <= S_DONE;
               endcase
            end
            S_APPLY: begin
               filtered_ff <= filt_in;
               if (log_room) begin
                  log_sum_ff   <= log_sum_ff + SUM_W'(filt_in);
                  log_count_ff <= log_count_ff + CNT_W'(1);
               end
               state_ff <= S_DONE;
            end
            S_DIV: begin
               if (div_rsp.done) begin
                  avg_ff       <= avg_in;
                  log_sum_ff   <= '0;
                  log_count_ff <= '0;
                  state_ff     <= S_DONE;
               end
            end
            S_DONE: begin
               if (rsp_load) begin
                  rsp_current_ff <= filtered_ff;
                  rsp_average_ff <= avg_ff;
                  rsp_count_ff   <= log_count_ff;
                  rsp_full_ff    <= (log_count_ff == CNT_W'(HISTORY_DEPTH));
                  rsp_valid_ff   <= 1'b1;
                  state_ff       <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_current_temp  = rsp_current_ff;
   assign rsp_average_temp  = rsp_average_ff;
   assign rsp_history_count = rsp_count_ff;
   assign rsp_history_full  = rsp_full_ff;

   `TSA_ASSERT_NOW(a_count_bound, 1'b1, log_count_ff <= CNT_W'(HISTORY_DEPTH), "history count past depth")
   `TSA_ASSERT_NOW(a_div_nonzero, div_req.start, div_req.divisor != '0, "divide started on empty history")
   `TSA_ASSERT_NEXT(a_avg_clears, (state_ff == S_DIV) && div_rsp.done, log_count_ff == '0, "average left history set")
   `TSA_ASSERT_NEXT(a_slew_step, (state_ff == S_APPLY) && item_ff.filter, (filtered_ff == $past(filtered_ff)) || (filtered_ff == $past(filtered_ff) + 14'sd1) || (filtered_ff == $past(filtered_ff) - 14'sd1), "filter moved more than one step")

endmodule

// File: sim/temp_sensor_slew_filter_average_test.sv
// self-checking testbench for the temperature sensor slew filter and history average
`timescale 1ns / 1ps

module temp_sensor_slew_filter_average_test;
   import tsa_pkg::*;

   // one response as the block reports it
   typedef struct {
      logic signed [TEMP_W-1:0] current_temp;
      logic signed [TEMP_W-1:0] average_temp;
      logic [CNT_W-1:0]         history_count;
      logic                     history_full;
   } reading_type;

   // one row of the directed table; known rows carry a hand-written response
   typedef struct {
      op_type op;
      int     sample;
      bit     filter;
      bit     known;
      int     cur;
      int     avg;
      int     cnt;
      bit     full;
   } row_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_valid;
   logic                       csr_ready;
   logic signed [OFFSET_W-1:0] csr_temp_offset;
   logic                       req_valid;
   logic                       req_ready;
   logic [1:0]                 req_kind;
   logic [SAMPLE_W-1:0]        req_adc_sample;
   logic                       req_filter_on;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [TEMP_W-1:0]   rsp_current_temp;
   logic signed [TEMP_W-1:0]   rsp_average_temp;
   logic [CNT_W-1:0]           rsp_history_count;
   logic                       rsp_history_full;

   temp_sensor_slew_filter_average dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_temp_offset   (csr_temp_offset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_adc_sample    (req_adc_sample),
      .req_filter_on     (req_filter_on),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_current_temp  (rsp_current_temp),
      .rsp_average_temp  (rsp_average_temp),
      .rsp_history_count (rsp_history_count),
      .rsp_history_full  (rsp_history_full)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow copy of the block state and the offset register
   int kept_temp;
   int hist_sum;
   int hist_count;
   int offset_reg;

   reading_type readings_due[$];
   row_type     directed_rows[24];

   int  fail_count;
   bit  reset_done;
   bit  send_quiet;
   bit  recv_quiet;
   int  n_measure, n_restart, n_average, n_unused, n_offsets, n_full, n_checked;

   // converts a sample to tenths of a degree, offset included; the divide
   // truncates toward zero like the block's signed quotient
   function automatic int sample_to_tenths(logic [SAMPLE_W-1:0] sample);
      int raw;
      raw = int'(sample) - ADC_ZERO;
      return (raw * SCALE_NUM) / (1 << SCALE_SHIFT) + offset_reg;
   endfunction

   function automatic void log_kept_temp();
      if (hist_count < HISTORY_DEPTH) begin
         hist_sum   += kept_temp;
         hist_count += 1;
      end
   endfunction

   // advances the shadow state by one request and returns the response it gives
   function automatic reading_type compute_reading(op_type op, logic [SAMPLE_W-1:0] sample,
                                                   logic filter);
      reading_type r;
      int t;
      int avg;
      avg = 0;
      case (op)
         OP_MEASURE, OP_RESTART: begin
            if (op == OP_RESTART) begin
               // restart empties the log and ignores the filter bit
               hist_sum   = 0;
               hist_count = 0;
            end
            t = sample_to_tenths(sample);
            if (filter && op == OP_MEASURE) begin
               if (t > kept_temp) kept_temp += 1;
               else if (t < kept_temp) kept_temp -= 1;
            end else begin
               kept_temp = t;
            end
            log_kept_temp();
         end
         OP_AVERAGE: begin
            // an empty log reports zero and stays empty
            if (hist_count != 0) begin
               avg        = hist_sum / hist_count;
               hist_sum   = 0;
               hist_count = 0;
            end
         end
         default: ;
      endcase
      r.current_temp  = kept_temp[TEMP_W-1:0];
      r.average_temp  = avg[TEMP_W-1:0];
      r.history_count = hist_count[CNT_W-1:0];
      r.history_full  = (hist_count == HISTORY_DEPTH);
      if (r.history_full) n_full++;
      return r;
   endfunction

   // samples lean toward the ends of the range and the area around zero degrees
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return SAMPLE_W'(ADC_ZERO - 10 + int'($urandom_range(0, 20)));
         default: return SAMPLE_W'($urandom_range(0, 4095));
      endcase
   endfunction

   // drives one request and waits for it to be taken; called at a rising edge
   // and returns at the edge that accepted it, with req_valid still high
   task automatic send_request(op_type op, logic [SAMPLE_W-1:0] sample, logic filter,
                               bit known = 1'b0, reading_type golden = '{default: '0});
      int gap;
      reading_type want;
      if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
      gap = send_quiet ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= op;
      req_adc_sample <= sample;
      req_filter_on  <= filter;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // shadow state moves on even where the row gives the response by hand
      want = compute_reading(op, sample, filter);
      readings_due.push_back(known ? golden : want);
      case (op)
         OP_MEASURE: n_measure++;
         OP_RESTART: n_restart++;
         OP_AVERAGE: n_average++;
         default:    n_unused++;
      endcase
   endtask

   // holds off new requests until every response has come back
   task automatic wait_for_readings();
      req_valid <= 1'b0;
      @(posedge clock);
      while (readings_due.size() != 0) @(posedge clock);
   endtask

   // offset write, only with the block idle
   task automatic write_offset(int value);
      wait_for_readings();
      repeat (4) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_temp_offset <= value[OFFSET_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      offset_reg = value;
      n_offsets++;
   endtask

   // mostly well-formed runs: optional restart, a burst of measurements, an
   // optional average; the rest single requests of any kind including the unused one
   task automatic run_random_phase(int quota, bit fill_first);
      int sent;
      int burst;
      op_type op;
      sent = 0;
      while (sent < quota) begin
         if ($urandom_range(0, 9) < 8) begin
            if ($urandom_range(0, 1) == 1) begin
               send_request(OP_RESTART, pick_sample(), 1'($urandom_range(0, 1)));
               sent++;
            end
            if (fill_first) begin
               // first run goes past a full log on purpose
               burst      = HISTORY_DEPTH + 5;
               fill_first = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
               burst = $urandom_range(HISTORY_DEPTH - 5, HISTORY_DEPTH + 10);
            end else begin
               burst = $urandom_range(1, 20);
            end
            repeat (burst) begin
               send_request(OP_MEASURE, pick_sample(), 1'($urandom_range(0, 1)));
               sent++;
            end
            if ($urandom_range(0, 4) != 0) begin
               send_request(OP_AVERAGE, pick_sample(), 1'($urandom_range(0, 1)));
               sent++;
            end
         end else begin
            op = op_type'($urandom_range(0, 3));
            send_request(op, pick_sample(), 1'($urandom_range(0, 1)));
            if (op != OP_NONE) sent++;
         end
         if ($urandom_range(0, 49) == 0) wait_for_readings();
      end
   endtask

   // stimulus
   initial begin
      reading_type golden;
      int          offsets[8];
      reset           <= 1'b1;
      csr_valid       <= 1'b0;
      csr_temp_offset <= '0;
      req_valid       <= 1'b0;
      req_kind        <= KIND_MEASURE;
      req_adc_sample  <= '0;
      req_filter_on   <= 1'b0;
      kept_temp  = 0;
      hist_sum   = 0;
      hist_count = 0;
      offset_reg = 0;
      fail_count = 0;

      // op, sample, filter, known, current, average, count, full
      directed_rows = '{
         '{OP_AVERAGE, 0,    0, 1, 0,     0,     0, 0},  // empty log right after reset
         '{OP_NONE,    4095, 1, 1, 0,     0,     0, 0},  // unused kind leaves state alone
         '{OP_MEASURE, 1855, 0, 1, 0,     0,     1, 0},  // sensor zero point
         '{OP_MEASURE, 1854, 0, 1, -1,    0,     2, 0},  // negative quotient truncates up
         '{OP_MEASURE, 1856, 0, 1, 1,     0,     3, 0},
         '{OP_MEASURE, 0,    0, 1, -3020, 0,     4, 0},  // coldest sample
         '{OP_MEASURE, 4095, 1, 1, -3019, 0,     5, 0},  // slew one step up
         '{OP_MEASURE, 4095, 0, 1, 3647,  0,     6, 0},  // hottest sample
         '{OP_MEASURE, 0,    1, 1, 3646,  0,     7, 0},  // slew one step down
         '{OP_AVERAGE, 0,    0, 0, 0,     0,     0, 0},
         '{OP_AVERAGE, 0,    0, 1, 3646,  0,     0, 0},  // second average sees an empty log
         '{OP_RESTART, 0,    1, 1, -3020, 0,     1, 0},  // restart ignores the filter bit
         '{OP_MEASURE, 0,    1, 1, -3020, 0,     2, 0},  // filter holds when already there
         '{OP_AVERAGE, 0,    0, 1, -3020, -3020, 0, 0},
         '{OP_MEASURE, 4095, 1, 0, 0,     0,     0, 0},
         '{OP_NONE,    1234, 0, 0, 0,     0,     0, 0},
         '{OP_RESTART, 4095, 1, 1, 3647,  0,     1, 0},
         '{OP_AVERAGE, 0,    0, 1, 3647,  3647,  0, 0},
         '{OP_MEASURE, 1000, 1, 0, 0,     0,     0, 0},
         '{OP_MEASURE, 3000, 0, 0, 0,     0,     0, 0},
         '{OP_AVERAGE, 0,    0, 0, 0,     0,     0, 0},
         '{OP_RESTART, 0,    0, 0, 0,     0,     0, 0},
         '{OP_MEASURE, 1854, 0, 0, 0,     0,     0, 0},
         '{OP_AVERAGE, 0,    0, 0, 0,     0,     0, 0}   // negative mean truncates up
      };

      // offset extremes and zero first, then random settings
      offsets[0] = -512;
      offsets[1] = 511;
      offsets[2] = 0;
      for (int i = 3; i < 8; i++) offsets[i] = int'($urandom_range(0, 1023)) - 512;

      repeat (4) @(posedge clock);
      reset      <= 1'b0;
      reset_done = 1'b1;

      // directed table at the reset offset
      foreach (directed_rows[i]) begin
         golden.current_temp  = directed_rows[i].cur[TEMP_W-1:0];
         golden.average_temp  = directed_rows[i].avg[TEMP_W-1:0];
         golden.history_count = directed_rows[i].cnt[CNT_W-1:0];
         golden.history_full  = directed_rows[i].full;
         send_request(directed_rows[i].op, directed_rows[i].sample[SAMPLE_W-1:0],
                      directed_rows[i].filter, directed_rows[i].known, golden);
      end

      // random phases, each under its own offset
      foreach (offsets[i]) begin
         write_offset(offsets[i]);
         run_random_phase(250, i == 0);
      end

      wait_for_readings();
      // the average divider is the longest path; watch for stray responses
      repeat (40) @(posedge clock);

      $display("checked %0d responses: %0d measure, %0d restart, %0d average, %0d unused kind",
               n_checked, n_measure, n_restart, n_average, n_unused);
      $display("%0d offset settings written, full history reported %0d times",
               n_offsets, n_full);
      if (fail_count == 0) begin
         $display("temp_sensor_slew_filter_average verification clean");
      end else begin
         $display("temp_sensor_slew_filter_average verification failed");
      end
      $finish;
   end

   // response side: random stalls, compare against the oldest expectation
   initial begin
      reading_type want;
      int          stall;
      rsp_ready <= 1'b0;
      wait (reset_done);
      forever begin
         if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
         stall = recv_quiet ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         n_checked++;
         if (readings_due.size() == 0) begin
            $error("response with no request outstanding");
            fail_count++;
         end else begin
            want = readings_due.pop_front();
            if (rsp_current_temp !== want.current_temp) begin
               $error("current_temp expected %0d, got %0d", want.current_temp,
                      rsp_current_temp);
               fail_count++;
            end
            if (rsp_average_temp !== want.average_temp) begin
               $error("average_temp expected %0d, got %0d", want.average_temp,
                      rsp_average_temp);
               fail_count++;
            end
            if (rsp_history_count !== want.history_count) begin
               $error("history_count expected %0d, got %0d", want.history_count,
                      rsp_history_count);
               fail_count++;
            end
            if (rsp_history_full !== want.history_full) begin
               $error("history_full expected %0d, got %0d", want.history_full,
                      rsp_history_full);
               fail_count++;
            end
         end
      end
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #2000000;
      $display("timeout with %0d responses outstanding", readings_due.size());
      $display("temp_sensor_slew_filter_average verification failed");
      $finish;
   end

endmodule
